// ----- src/ghash_pkg.sv -----
// ghash_pkg: types, codes and constants shared by the GHASH accumulator.
// No dependencies; imported by every other file in src.
`timescale 1ns / 1ps

package ghash_pkg;

   localparam int BLOCK_W     = 128;
   localparam int BLOCK_BYTES = 16;
   localparam int HALF_W      = 64;
   localparam int BYTES_W     = 5;
   localparam int COUNT_W     = 61;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 64;

   // Low taps of x^128 + x^7 + x^2 + x + 1 in plain bit order (0xE1 reflected).
   localparam logic [7:0] GCM_POLY_LO = 8'h87;

   typedef enum logic [1:0] {
      FUNC_CLEAR = 2'd0,
      FUNC_AAD   = 2'd1,
      FUNC_TEXT  = 2'd2,
      FUNC_FINAL = 2'd3
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_HI = 1'b0,
      CSR_KEY_LO = 1'b1
   } csr_idx_type;

   typedef struct packed {
      func_type            func;
      logic [HALF_W-1:0]   data_hi;
      logic [HALF_W-1:0]   data_lo;
      logic [BYTES_W-1:0]  data_bytes;
   } req_type;

   typedef struct packed {
      logic [HALF_W-1:0]   hash_hi;
      logic [HALF_W-1:0]   hash_lo;
      logic                is_final;
   } rsp_type;

   // Beat held in the input register: padded block and saturated byte count.
   typedef struct packed {
      func_type            func;
      logic [BLOCK_W-1:0]  block;
      logic [BYTES_W-1:0]  nbytes;
   } stage_type;

endpackage

// ----- src/ghash_ingress.sv -----
// ghash_ingress: input register of the GHASH accumulator; zero-pads short blocks.
// Depends on ghash_pkg.
`timescale 1ns / 1ps

module ghash_ingress import ghash_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  req_type   req,
   input  logic      advance,
   output logic      stage_valid,
   output stage_type stage
);

   logic      valid_ff, valid_in;
   stage_type stage_ff, stage_in;
   logic [BYTES_W-1:0] nsat;
   logic [BLOCK_W-1:0] raw;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      nsat = (req.data_bytes > BYTES_W'(BLOCK_BYTES)) ? BYTES_W'(BLOCK_BYTES)
                                                      : req.data_bytes;
      raw  = {req.data_hi, req.data_lo};
      stage_in.func   = req.func;
      stage_in.nbytes = nsat;
      for (int j = 0; j < BLOCK_BYTES; j++) begin
         stage_in.block[BLOCK_W-1-8*j -: 8] =
            raw[BLOCK_W-1-8*j -: 8] & {8{BYTES_W'(j) < nsat}};
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ----- src/ghash_gfmul.sv -----
// ghash_gfmul: combinational GF(2^128) multiply in GCM bit order.
// Carry-less product through an XOR tree, then folding by the GCM polynomial. Uses ghash_pkg.
`timescale 1ns / 1ps

module ghash_gfmul import ghash_pkg::*; (
   input  logic [BLOCK_W-1:0] x,
   input  logic [BLOCK_W-1:0] h,
   output logic [BLOCK_W-1:0] z
);

   localparam int PW   = 2*BLOCK_W - 1;
   localparam int HW   = BLOCK_W - 1;
   localparam int TW   = HW + 7;
   localparam int GW   = TW - BLOCK_W;

   // GCM bit 0 is the MSB of byte 0; flip to plain polynomial order.
   function automatic logic [BLOCK_W-1:0] flip(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      for (int k = 0; k < BLOCK_W; k++) begin
         r[k] = v[BLOCK_W-1-k];
      end
      return r;
   endfunction

   logic [BLOCK_W-1:0] xr, hr;
   logic [PW-1:0]      node [2*BLOCK_W-1];
   logic [HW-1:0]      hi_part;
   logic [TW-1:0]      fold1;
   logic [GW-1:0]      over;
   logic [BLOCK_W-1:0] fold2;
   logic [BLOCK_W-1:0] rem;

   assign xr = flip(x);
   assign hr = flip(h);

   // Leaves: one shifted copy of H per set bit of X.
   for (genvar i = 0; i < BLOCK_W; i++) begin : g_leaf
      assign node[BLOCK_W-1+i] = xr[i] ? (PW'(hr) << i) : '0;
   end

   // Balanced XOR tree, root at node 0.
   for (genvar k = 0; k < BLOCK_W-1; k++) begin : g_tree
      assign node[k] = node[2*k+1] ^ node[2*k+2];
   end

   always_comb begin
      hi_part = node[0][PW-1:BLOCK_W];
      fold1   = '0;
      for (int j = 0; j < 8; j++) begin
         if (GCM_POLY_LO[j]) begin
            fold1 = fold1 ^ (TW'(hi_part) << j);
         end
      end
      over  = fold1[TW-1:BLOCK_W];
      fold2 = '0;
      for (int j = 0; j < 8; j++) begin
         if (GCM_POLY_LO[j]) begin
            fold2 = fold2 ^ (BLOCK_W'(over) << j);
         end
      end
      rem = node[0][BLOCK_W-1:0] ^ fold1[BLOCK_W-1:0] ^ fold2;
   end

   assign z = flip(rem);

endmodule

// ----- src/ghash_accumulator.sv -----
// GHASH accumulator for GCM: XOR each block into the hash, multiply by H.
// A req beat is held in the input register, then in the result register, until it leaves as its rsp beat.
// Throughput: one beat per cycle unless a held rsp beat is not taken; the loop is one GF(2^128)
// multiply from the input register and accumulator back into the accumulator and result register.
// Reset (synchronous): accumulator, byte counters, hash key and valid flags cleared.
// Uses ghash_pkg, ghash_ingress and ghash_gfmul.
`timescale 1ns / 1ps

module ghash_accumulator import ghash_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_idx,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic               stage_valid;
   stage_type          stage;
   logic               advance;

   logic [HALF_W-1:0]  key_hi_ff, key_hi_in;
   logic [HALF_W-1:0]  key_lo_ff, key_lo_in;
   logic [BLOCK_W-1:0] acc_ff, acc_in;
   logic [COUNT_W-1:0] ad_cnt_ff, ad_cnt_in;
   logic [COUNT_W-1:0] text_cnt_ff, text_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [BLOCK_W-1:0] mul_x, mul_z;
   logic [BLOCK_W-1:0] len_block;

   ghash_ingress u_ingress (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req         (req),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   ghash_gfmul u_gfmul (
      .x (mul_x),
      .h ({key_hi_ff, key_lo_ff}),
      .z (mul_z)
   );

   assign advance = stage_valid && (!rsp_valid_ff || rsp_ready);

   // Key registers
   always_comb begin
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      if (csr_wr_en) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_KEY_HI: key_hi_in = csr_wdata;
            CSR_KEY_LO: key_lo_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Bit lengths, 64 bits big-endian each.
   assign len_block = {ad_cnt_ff, 3'b000, text_cnt_ff, 3'b000};

   always_comb begin
      mul_x = acc_ff ^ ((stage.func == FUNC_FINAL) ? len_block : stage.block);
   end

   always_comb begin
      acc_in      = acc_ff;
      ad_cnt_in   = ad_cnt_ff;
      text_cnt_in = text_cnt_ff;
      if (advance) begin
         case (stage.func)
            FUNC_CLEAR: begin
               acc_in      = '0;
               ad_cnt_in   = '0;
               text_cnt_in = '0;
            end
            FUNC_AAD: begin
               if (stage.nbytes != '0) begin
                  acc_in    = mul_z;
                  ad_cnt_in = ad_cnt_ff + COUNT_W'(stage.nbytes);
               end
            end
            FUNC_TEXT: begin
               if (stage.nbytes != '0) begin
                  acc_in      = mul_z;
                  text_cnt_in = text_cnt_ff + COUNT_W'(stage.nbytes);
               end
            end
            FUNC_FINAL: acc_in = mul_z;
            default: ;
         endcase
      end
   end

   // Result register: loads on advance, drains when the beat is taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_in.hash_hi  = acc_in[BLOCK_W-1:HALF_W];
      rsp_in.hash_lo  = acc_in[HALF_W-1:0];
      rsp_in.is_final = (stage.func == FUNC_FINAL);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff    <= '0;
         key_lo_ff    <= '0;
         acc_ff       <= '0;
         ad_cnt_ff    <= '0;
         text_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_hi_ff    <= key_hi_in;
         key_lo_ff    <= key_lo_in;
         acc_ff       <= acc_in;
         ad_cnt_ff    <= ad_cnt_in;
         text_cnt_ff  <= text_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // The beat on offer always carries the live accumulator.
   a_rsp_matches_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ({rsp_ff.hash_hi, rsp_ff.hash_lo} == acc_ff))
      else $error("rsp beat differs from accumulator");

   a_clear_gives_zero: assert property (@(posedge clock) disable iff (reset)
      (advance && stage.func == FUNC_CLEAR) |=>
         (acc_ff == '0 && ad_cnt_ff == '0 && text_cnt_ff == '0 && !rsp_ff.is_final))
      else $error("clear beat left state behind");

   a_counts_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(ad_cnt_ff) && $stable(text_cnt_ff) && $stable(acc_ff)))
      else $error("hash state moved without a beat");

   a_stall_holds_stage: assert property (@(posedge clock) disable iff (reset)
      (stage_valid && rsp_valid_ff && !rsp_ready) |=> (stage_valid && $stable(stage)))
      else $error("stalled beat lost from input register");

endmodule

// ----- tb/ghash_accumulator_test.sv -----
// ghash_accumulator_test: self-checking bench for the GHASH accumulator.
// Directed table, then random GCM messages and noise under random idling on both
// channels, checked against a bit-serial GF(2^128) predictor. Needs ghash_pkg.
`timescale 1ns / 1ps

module ghash_accumulator_test;
   import ghash_pkg::*;

   localparam int          WATCHDOG_LIMIT = 2000;
   localparam int          RANDOM_BEATS   = 650;
   localparam int          PHASE_BEATS    = 80;
   localparam int          DIR_ROWS       = 23;
   localparam logic [7:0]  GCM_REDUCE     = 8'hE1;
   localparam logic [63:0] F64            = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Z64            = 64'h0;
   localparam logic [63:0] PAT_A          = 64'h0123_4567_89AB_CDEF;
   localparam logic [63:0] PAT_B          = 64'hFEDC_BA98_7654_3210;
   // multiplicative identity in GCM bit order: bit 0 of the block is the msb
   localparam logic [127:0] KEY_ONE       = {1'b1, 127'b0};
   localparam logic [127:0] KEY_TOP       = {64'h0, 64'h1};
   localparam logic [127:0] Z128          = '0;
   localparam logic [127:0] F128          = '1;

   typedef struct packed {
      logic          rekey;
      logic [127:0]  key;
      func_type      func;
      logic [63:0]   dh;
      logic [63:0]   dl;
      logic [4:0]    nbytes;
      logic          known;
      logic [127:0]  want;
      logic          want_final;
   } dir_row_type;

   // typed rows run with H = 0 (hash zero) or H = 1 (plain XOR), but for the closing clear
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{1'b0, Z128,    FUNC_AAD,   F64,   F64,   5'd16, 1'b1, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_FINAL, F64,   F64,   5'd16, 1'b1, Z128, 1'b1},
      '{1'b1, KEY_ONE, FUNC_CLEAR, F64,   F64,   5'd0,  1'b1, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_AAD,   F64,   F64,   5'd16, 1'b1, F128, 1'b0},
      '{1'b0, Z128,    FUNC_TEXT,  F64,   F64,   5'd1,  1'b1,
        {64'h00FF_FFFF_FFFF_FFFF, F64}, 1'b0},
      '{1'b0, Z128,    FUNC_TEXT,  F64,   F64,   5'd0,  1'b1,
        {64'h00FF_FFFF_FFFF_FFFF, F64}, 1'b0},
      '{1'b0, Z128,    FUNC_AAD,   F64,   F64,   5'd31, 1'b1,
        {64'hFF00_0000_0000_0000, Z64}, 1'b0},
      '{1'b0, Z128,    FUNC_TEXT,  PAT_A, PAT_B, 5'd9,  1'b1,
        {64'hFE23_4567_89AB_CDEF, 64'hFE00_0000_0000_0000}, 1'b0},
      '{1'b0, Z128,    FUNC_FINAL, PAT_A, PAT_B, 5'd16, 1'b1,
        {64'hFE23_4567_89AB_CCEF, 64'hFE00_0000_0000_0050}, 1'b1},
      '{1'b0, Z128,    FUNC_FINAL, Z64,   Z64,   5'd0,  1'b1,
        {64'hFE23_4567_89AB_CDEF, 64'hFE00_0000_0000_0000}, 1'b1},
      '{1'b0, Z128,    FUNC_CLEAR, PAT_A, PAT_B, 5'd17, 1'b1, Z128, 1'b0},
      '{1'b1, F128,    FUNC_AAD,   PAT_A, PAT_B, 5'd16, 1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_AAD,   64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
        5'd17, 1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_TEXT,  F64,   F64,   5'd8,  1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_TEXT,  F64,   F64,   5'd15, 1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_TEXT,  64'h8000_0000_0000_0001, 64'h1, 5'd7,
        1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_FINAL, Z64,   Z64,   5'd16, 1'b0, Z128, 1'b0},
      '{1'b1, KEY_TOP, FUNC_AAD,   64'h8000_0000_0000_0000, Z64, 5'd16,
        1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_TEXT,  F64,   Z64,   5'd3,  1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_AAD,   F64,   F64,   5'd2,  1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_FINAL, F64,   F64,   5'd31, 1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_FINAL, Z64,   Z64,   5'd0,  1'b0, Z128, 1'b0},
      '{1'b0, Z128,    FUNC_CLEAR, F64,   F64,   5'd16, 1'b1, Z128, 1'b0}
   };

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req       = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_idx   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic [127:0]  hash_key;
   logic [127:0]  hash_acc;
   logic [60:0]   ad_bytes_seen;
   logic [60:0]   text_bytes_seen;

   rsp_type       hash_expected [$];
   rsp_type       hash_want;
   int            mismatches  = 0;
   int            beats_sent  = 0;
   int            gap_mode    = 0;
   int            stall_mode  = 0;
   int            stall_left  = 0;
   int            stall_roll;
   int            idle_cycles = 0;

   ghash_accumulator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp),
      .csr_wr_en (csr_wr_en),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // bit-serial multiply, V shifted right and reduced whenever a one falls off
   function automatic logic [127:0] gf_mult(logic [127:0] x, logic [127:0] h);
      logic [127:0] z;
      logic [127:0] v;
      logic         carry;
      z = '0;
      v = h;
      for (int i = 0; i < 128; i++) begin
         if (x[127-i])
            z ^= v;
         carry = v[0];
         v = v >> 1;
         if (carry)
            v[127:120] ^= GCM_REDUCE;
      end
      return z;
   endfunction

   function automatic rsp_type ghash_step(req_type b);
      rsp_type      r;
      int           n;
      logic [127:0] mask;
      n = (b.data_bytes > 16) ? 16 : int'(b.data_bytes);
      r.is_final = 1'b0;
      case (b.func)
         FUNC_CLEAR: begin
            hash_acc        = '0;
            ad_bytes_seen   = '0;
            text_bytes_seen = '0;
         end
         FUNC_FINAL: begin
            hash_acc   = gf_mult(hash_acc ^ {ad_bytes_seen, 3'b0, text_bytes_seen, 3'b0},
                                 hash_key);
            r.is_final = 1'b1;
         end
         default: begin
            if (n != 0) begin
               mask     = ~(F128 >> (8 * n));
               hash_acc = gf_mult(hash_acc ^ ({b.data_hi, b.data_lo} & mask), hash_key);
               if (b.func == FUNC_AAD)
                  ad_bytes_seen += 61'(n);
               else
                  text_bytes_seen += 61'(n);
            end
         end
      endcase
      r.hash_hi = hash_acc[127:64];
      r.hash_lo = hash_acc[63:0];
      return r;
   endfunction

   function automatic int pick_idle(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == 0 || roll < 70)
         return 0;
      if (roll < 95 || mode == 1)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_type make_beat(func_type f, int nb);
      req_type b;
      b.func       = f;
      b.data_hi    = {$urandom, $urandom};
      b.data_lo    = {$urandom, $urandom};
      b.data_bytes = 5'(nb);
      return b;
   endfunction

   task automatic report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      mismatches++;
   endtask

   // one beat; returns in the time step of the accepting edge
   task automatic send_beat(req_type b, logic known, rsp_type typed);
      int      gap;
      rsp_type predicted;
      gap = pick_idle(gap_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req       <= b;
      do @(posedge clock); while (!req_ready);
      predicted = ghash_step(b);
      hash_expected.push_back(known ? typed : predicted);
      beats_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (hash_expected.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // which: 1 high half only, 2 low half only, otherwise both
   task automatic write_key(logic [127:0] k, int which);
      if (which != 2) begin
         csr_wr_en <= 1'b1;
         csr_idx   <= CSR_KEY_HI;
         csr_wdata <= k[127:64];
         @(posedge clock);
         hash_key[127:64] = k[127:64];
      end
      if (which != 1) begin
         csr_wr_en <= 1'b1;
         csr_idx   <= CSR_KEY_LO;
         csr_wdata <= k[63:0];
         @(posedge clock);
         hash_key[63:0] = k[63:0];
      end
      csr_wr_en <= 1'b0;
   endtask

   // clear, AD, text, rarely another AD, lengths (rarely twice); last blocks may be short
   task automatic send_message();
      int n_ad;
      int n_text;
      n_ad   = $urandom_range(0, 3);
      n_text = $urandom_range(0, 5);
      send_beat(make_beat(FUNC_CLEAR, $urandom_range(0, 31)), 1'b0, '0);
      for (int i = 0; i < n_ad; i++)
         send_beat(make_beat(FUNC_AAD, (i == n_ad - 1) ? $urandom_range(1, 16) : 16),
                   1'b0, '0);
      for (int i = 0; i < n_text; i++)
         send_beat(make_beat(FUNC_TEXT, (i == n_text - 1) ? $urandom_range(1, 16) : 16),
                   1'b0, '0);
      if ($urandom_range(0, 7) == 0)
         send_beat(make_beat(FUNC_AAD, $urandom_range(1, 16)), 1'b0, '0);
      send_beat(make_beat(FUNC_FINAL, $urandom_range(0, 31)), 1'b0, '0);
      if ($urandom_range(0, 9) == 0)
         send_beat(make_beat(FUNC_FINAL, $urandom_range(0, 31)), 1'b0, '0);
   endtask

   function automatic logic [127:0] pick_key();
      case ($urandom_range(0, 7))
         0:       return Z128;
         1:       return F128;
         2:       return KEY_ONE;
         3:       return KEY_TOP;
         default: return {$urandom, $urandom, $urandom, $urandom};
      endcase
   endfunction

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         stall_roll = pick_idle(stall_mode);
         rsp_ready  <= (stall_roll == 0);
         stall_left <= (stall_roll > 0) ? stall_roll - 1 : 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (hash_expected.size() == 0) begin
            report($sformatf("result beat with nothing pending: %h", rsp));
         end else begin
            hash_want = hash_expected.pop_front();
            if (rsp.hash_hi !== hash_want.hash_hi)
               report($sformatf("hash_hi %h, want %h", rsp.hash_hi, hash_want.hash_hi));
            if (rsp.hash_lo !== hash_want.hash_lo)
               report($sformatf("hash_lo %h, want %h", rsp.hash_lo, hash_want.hash_lo));
            if (rsp.is_final !== hash_want.is_final)
               report($sformatf("is_final %b, want %b", rsp.is_final, hash_want.is_final));
         end
      end
   end

   // watchdog: cycles with no beat accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL ghash_accumulator");
         $finish;
      end
   end

   initial begin
      int      random_start;
      int      phase_end;
      rsp_type typed;
      hash_key        = '0;
      hash_acc        = '0;
      ad_bytes_seen   = '0;
      text_bytes_seen = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         if (directed_rows[i].rekey) begin
            drain();
            write_key(directed_rows[i].key, 0);
         end
         typed.hash_hi  = directed_rows[i].want[127:64];
         typed.hash_lo  = directed_rows[i].want[63:0];
         typed.is_final = directed_rows[i].want_final;
         send_beat('{func: directed_rows[i].func, data_hi: directed_rows[i].dh,
                     data_lo: directed_rows[i].dl, data_bytes: directed_rows[i].nbytes},
                   directed_rows[i].known, typed);
      end

      random_start = beats_sent;
      while (beats_sent - random_start < RANDOM_BEATS) begin
         drain();
         write_key(pick_key(), $urandom_range(0, 3));
         gap_mode   = $urandom_range(0, 2);
         stall_mode = $urandom_range(0, 2);
         phase_end  = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 9) < 8)
               send_message();
            else
               send_beat(make_beat(func_type'($urandom_range(0, 3)), $urandom_range(0, 31)),
                         1'b0, '0);
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (mismatches == 0)
         $display("PASS ghash_accumulator");
      else
         $display("FAIL ghash_accumulator");
      $finish;
   end

endmodule

// ----- sim.f -----
src/ghash_pkg.sv
src/ghash_ingress.sv
src/ghash_gfmul.sv
src/ghash_accumulator.sv
tb/ghash_accumulator_test.sv
